>>> sv/pau_pkg.sv
// Shared constants and types for the primitive assembler unit.
// Used by every module of the block; has no dependencies of its own.
package pau_pkg;

   // Topology register codes.
   localparam logic [2:0] TOPO_POINT      = 3'd0;
   localparam logic [2:0] TOPO_LINE_LIST  = 3'd1;
   localparam logic [2:0] TOPO_LINE_STRIP = 3'd2;
   localparam logic [2:0] TOPO_LINE_LOOP  = 3'd3;
   localparam logic [2:0] TOPO_TRI_LIST   = 3'd4;
   localparam logic [2:0] TOPO_TRI_STRIP  = 3'd5;
   localparam logic [2:0] TOPO_TRI_FAN    = 3'd6;

   // Primitive kind codes.
   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_TRI   = 2'd2;

   // Register indexes, decoded from address bit 2.
   localparam logic REG_TOPOLOGY       = 1'b0;
   localparam logic REG_PROVOKING_LAST = 1'b1;

   // Number of jobs held between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0] topology;
      logic       provoking_last;
      logic       clear;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> sv/pau_front.sv
// Front end of the primitive assembler: vertex history and primitive formation.
// Depends on pau_pkg for topology and kind codes and the configuration struct.
module pau_front #(
   parameter int HANDLE_BITS = 16,
   parameter int JOB_BITS    = 2 * (3 + 4 * 16) + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pau_pkg::cfg_type       cfg,
   input  logic                   accept,
   input  logic [HANDLE_BITS-1:0] vertex_handle,
   input  logic                   end_of_draw,
   output logic                   push,
   output logic [JOB_BITS-1:0]    job
);

   localparam int PRIM_BITS = 3 + 4 * HANDLE_BITS;

   logic [HANDLE_BITS-1:0] hub_ff, hub_in;
   logic [HANDLE_BITS-1:0] older_ff, older_in;
   logic [HANDLE_BITS-1:0] newer_ff, newer_in;
   logic [1:0]             seen_ff, seen_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   parity_ff, parity_in;

   logic                   emit0;
   logic                   two;
   logic [1:0]             kind0;
   logic [HANDLE_BITS-1:0] a0, b0, c0, p0;
   logic [HANDLE_BITS-1:0] close_hub;
   logic [1:0]             seen_bump;

   function automatic logic [PRIM_BITS-1:0] make_prim(
      input logic [1:0]             kind,
      input logic [HANDLE_BITS-1:0] a,
      input logic [HANDLE_BITS-1:0] b,
      input logic [HANDLE_BITS-1:0] c,
      input logic [HANDLE_BITS-1:0] p,
      input logic                   last);
      return {last, p, c, b, a, kind};
   endfunction

   assign seen_bump = (seen_ff == 2'd3) ? seen_ff : seen_ff + 2'd1;

   always_comb begin
      hub_in    = hub_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      emit0     = 1'b0;
      two       = 1'b0;
      kind0     = pau_pkg::KIND_POINT;
      a0        = '0;
      b0        = '0;
      c0        = '0;
      p0        = '0;
      close_hub = hub_ff;

      unique case (cfg.topology)
         pau_pkg::TOPO_POINT: begin
            emit0 = 1'b1;
            a0    = vertex_handle;
         end
         pau_pkg::TOPO_LINE_LIST: begin
            if (phase_ff == 2'd0) begin
               older_in = vertex_handle;
               phase_in = 2'd1;
            end else begin
               emit0    = 1'b1;
               kind0    = pau_pkg::KIND_LINE;
               a0       = older_ff;
               b0       = vertex_handle;
               phase_in = 2'd0;
            end
         end
         pau_pkg::TOPO_LINE_STRIP: begin
            if (seen_ff != 2'd0) begin
               emit0 = 1'b1;
               kind0 = pau_pkg::KIND_LINE;
               a0    = newer_ff;
               b0    = vertex_handle;
            end
            newer_in = vertex_handle;
            seen_in  = seen_bump;
         end
         pau_pkg::TOPO_LINE_LOOP: begin
            if (seen_ff == 2'd0) begin
               hub_in    = vertex_handle;
               close_hub = vertex_handle;
            end else begin
               emit0 = 1'b1;
               kind0 = pau_pkg::KIND_LINE;
               a0    = newer_ff;
               b0    = vertex_handle;
            end
            newer_in = vertex_handle;
            seen_in  = seen_bump;
            // The closing line rides in the second slot, or alone in the first.
            if (end_of_draw) begin
               if (emit0) begin
                  two = 1'b1;
               end else begin
                  emit0 = 1'b1;
                  kind0 = pau_pkg::KIND_LINE;
                  a0    = vertex_handle;
                  b0    = close_hub;
               end
            end
         end
         pau_pkg::TOPO_TRI_LIST: begin
            if (phase_ff == 2'd0) begin
               older_in = vertex_handle;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               newer_in = vertex_handle;
               phase_in = 2'd2;
            end else begin
               emit0    = 1'b1;
               kind0    = pau_pkg::KIND_TRI;
               a0       = older_ff;
               b0       = newer_ff;
               c0       = vertex_handle;
               p0       = cfg.provoking_last ? vertex_handle : older_ff;
               phase_in = 2'd0;
            end
         end
         pau_pkg::TOPO_TRI_STRIP: begin
            if (seen_ff[1]) begin
               emit0     = 1'b1;
               kind0     = pau_pkg::KIND_TRI;
               a0        = parity_ff ? newer_ff : older_ff;
               b0        = parity_ff ? older_ff : newer_ff;
               c0        = vertex_handle;
               p0        = cfg.provoking_last ? vertex_handle : older_ff;
               parity_in = ~parity_ff;
            end
            older_in = newer_ff;
            newer_in = vertex_handle;
            seen_in  = seen_bump;
         end
         pau_pkg::TOPO_TRI_FAN: begin
            if (seen_ff == 2'd0) begin
               hub_in = vertex_handle;
            end else if (seen_ff[1]) begin
               emit0 = 1'b1;
               kind0 = pau_pkg::KIND_TRI;
               a0    = hub_ff;
               b0    = newer_ff;
               c0    = vertex_handle;
               p0    = cfg.provoking_last ? vertex_handle : newer_ff;
            end
            newer_in = vertex_handle;
            seen_in  = seen_bump;
         end
         default: begin
         end
      endcase

      if (end_of_draw) begin
         hub_in    = '0;
         older_in  = '0;
         newer_in  = '0;
         seen_in   = '0;
         phase_in  = '0;
         parity_in = 1'b0;
      end
   end

   assign push = accept & emit0;
   assign job  = {two,
                  make_prim(pau_pkg::KIND_LINE, vertex_handle, close_hub, '0, '0, 1'b1),
                  make_prim(kind0, a0, b0, c0, p0, ~two)};

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         hub_ff    <= '0;
         older_ff  <= '0;
         newer_ff  <= '0;
         seen_ff   <= '0;
         phase_ff  <= '0;
         parity_ff <= 1'b0;
      end else if (accept) begin
         hub_ff    <= hub_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         seen_ff   <= seen_in;
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
      end
   end

endmodule

>>> sv/pau_queue.sv
// Short job queue between the assembler front end and the output back end.
// Depends on pau_pkg for the queue depth and the status struct.
module pau_queue #(
   parameter int JOB_BITS = 2 * (3 + 4 * 16) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [JOB_BITS-1:0]       push_data,
   input  logic                      pop,
   output logic [JOB_BITS-1:0]       pop_data,
   output pau_pkg::queue_status_type status
);

   localparam int DEPTH    = pau_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [JOB_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/pau_back.sv
// Back end of the primitive assembler: takes jobs from the queue and drives
// one primitive per beat from its output register. Depends on pau_pkg.
module pau_back #(
   parameter int HANDLE_BITS = 16,
   parameter int JOB_BITS    = 2 * (3 + 4 * 16) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [JOB_BITS-1:0]       job,
   input  pau_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [1:0]                prim_kind,
   output logic [HANDLE_BITS-1:0]    corner_a,
   output logic [HANDLE_BITS-1:0]    corner_b,
   output logic [HANDLE_BITS-1:0]    corner_c,
   output logic [HANDLE_BITS-1:0]    provoking_handle,
   output logic                      last_of_run
);

   localparam int PRIM_BITS = 3 + 4 * HANDLE_BITS;

   logic [JOB_BITS-1:0]  job_ff, job_in;
   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic [PRIM_BITS-1:0] prim;
   logic                 two;
   logic                 final_beat;
   logic                 take;
   logic                 load;

   assign two        = job_ff[JOB_BITS-1];
   assign prim       = phase_ff ? job_ff[2*PRIM_BITS-1:PRIM_BITS] : job_ff[PRIM_BITS-1:0];
   assign take       = busy_ff & out_ready;
   assign final_beat = phase_ff | ~two;
   // A new job enters as the last beat of the current one goes out.
   assign load       = ~busy_ff | (take & final_beat);
   assign pop        = load & ~status.empty;

   always_comb begin
      job_in   = job_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (load) begin
         job_in   = job;
         busy_in  = ~status.empty;
         phase_in = 1'b0;
      end else if (take) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign out_valid        = busy_ff;
   assign prim_kind        = prim[1:0];
   assign corner_a         = prim[2+:HANDLE_BITS];
   assign corner_b         = prim[2+HANDLE_BITS+:HANDLE_BITS];
   assign corner_c         = prim[2+2*HANDLE_BITS+:HANDLE_BITS];
   assign provoking_handle = prim[2+3*HANDLE_BITS+:HANDLE_BITS];
   assign last_of_run      = prim[PRIM_BITS-1];

endmodule

>>> sv/primitive_assembler_unit.sv
// Top level of the primitive assembler unit: register port, front end,
// job queue and back end. Depends on pau_pkg, pau_front, pau_queue, pau_back.
//
// The unit takes one vertex handle per cycle while req_tready is high and
// forms points, lines or triangles for the configured topology, each with
// its provoking vertex. Each accepted vertex is handled in the cycle it
// arrives; the primitives it causes wait as one job in a four-entry queue,
// and the output register drives one primitive per cycle while rsp_tready
// is high. A sustained rate of one vertex per cycle holds while the result
// side keeps up; the last vertex of a line loop can yield two beats, which
// the queue absorbs. Registers: topology at byte address 0 (a write clears
// the assembly state, as at the start of a draw) and provoking_last at 4.
module primitive_assembler_unit #(
   parameter int HANDLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // Fields from bit 0 up: vertex_handle.
   input  logic [((HANDLE_BITS+7)/8)*8-1:0]          req_tdata,
   input  logic                                      req_tlast,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // Fields from bit 0 up: corner_a, corner_b, corner_c, provoking_handle.
   output logic [((4*HANDLE_BITS+7)/8)*8-1:0]        rsp_tdata,
   // Fields from bit 0 up: prim_kind.
   output logic [1:0]                                rsp_tuser,
   output logic                                      rsp_tlast,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [2:0]                                csr_paddr,
   input  logic [31:0]                               csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);

   localparam int RSP_BITS = ((4 * HANDLE_BITS + 7) / 8) * 8;
   localparam int JOB_BITS = 2 * (3 + 4 * HANDLE_BITS) + 1;

   logic [2:0]                topology_ff;
   logic                      provoking_last_ff;
   logic                      csr_write;
   pau_pkg::cfg_type          cfg;
   pau_pkg::queue_status_type status;
   logic                      accept;
   logic                      push;
   logic                      pop;
   logic [JOB_BITS-1:0]       push_job;
   logic [JOB_BITS-1:0]       pop_job;
   logic [HANDLE_BITS-1:0]    corner_a;
   logic [HANDLE_BITS-1:0]    corner_b;
   logic [HANDLE_BITS-1:0]    corner_c;
   logic [HANDLE_BITS-1:0]    provoking_handle;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff       <= pau_pkg::TOPO_POINT;
         provoking_last_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == pau_pkg::REG_TOPOLOGY) begin
            topology_ff <= csr_pwdata[2:0];
         end else begin
            provoking_last_ff <= csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == pau_pkg::REG_PROVOKING_LAST)
                       ? {31'd0, provoking_last_ff} : {29'd0, topology_ff};

   assign cfg.topology       = topology_ff;
   assign cfg.provoking_last = provoking_last_ff;
   assign cfg.clear          = csr_write & (csr_paddr[2] == pau_pkg::REG_TOPOLOGY);

   assign req_tready = ~status.full;
   assign accept     = req_tvalid & req_tready;

   pau_front #(
      .HANDLE_BITS (HANDLE_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .vertex_handle (req_tdata[HANDLE_BITS-1:0]),
      .end_of_draw   (req_tlast),
      .push          (push),
      .job           (push_job)
   );

   pau_queue #(
      .JOB_BITS (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (status)
   );

   pau_back #(
      .HANDLE_BITS (HANDLE_BITS),
      .JOB_BITS    (JOB_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (pop_job),
      .status           (status),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .prim_kind        (rsp_tuser),
      .corner_a         (corner_a),
      .corner_b         (corner_b),
      .corner_c         (corner_c),
      .provoking_handle (provoking_handle),
      .last_of_run      (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({provoking_handle, corner_c, corner_b, corner_a});

endmodule
